### design/mrpc_pkg.sv
`timescale 1ns / 1ps
package mrpc_pkg;

  typedef struct packed {
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] a_z;
    logic signed [31:0] b_x;
    logic signed [31:0] b_y;
    logic signed [31:0] b_z;
  } req_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic [1:0]         status;
  } rsp_t;

  typedef struct packed {
    logic       zero;
    logic [2:0] neg;
    logic [2:0] ovf;
  } flags_t;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_SAT  = 2'd1;
  localparam logic [1:0] ST_ZERO = 2'd2;

  localparam int QBITS = 32;
  localparam logic [31:0] SAT_POS = 32'h7fff_ffff;
  localparam logic [31:0] SAT_NEG = 32'h8000_0000;

  // signed width of the denominator
  function automatic int mrpc_dsw(int f);
    int mx;
    mx = (4 * f > 130) ? 4 * f : 130;
    return mx + 3;
  endfunction

  // signed width of the numerator before scaling
  function automatic int mrpc_nw(int f);
    return ((2 * f + 32 > 96) ? 2 * f + 32 : 96) + 4;
  endfunction

  // width of the scaled dividend
  function automatic int mrpc_xw(int f);
    int a;
    int b;
    a = mrpc_nw(f) + 2 * f;
    b = mrpc_dsw(f) - 1;
    return ((a > b) ? a : b) + 1;
  endfunction

  // partial remainder width
  function automatic int mrpc_rw(int f);
    return mrpc_dsw(f) + 1;
  endfunction

  // width of the overflow compare
  function automatic int mrpc_cw(int f);
    int a;
    int b;
    a = mrpc_xw(f);
    b = mrpc_dsw(f) + QBITS;
    return (a > b) ? a : b;
  endfunction

endpackage

### design/mrpc_front.sv
`timescale 1ns / 1ps
module mrpc_front #(
  parameter int FRAC_BITS = 28
) (
  input  logic                                            clk,
  input  logic                                            rst,
  input  logic                                            en,
  input  logic                                            vld,
  input  mrpc_pkg::req_t                                  data,
  output logic                                            stage_vld,
  output logic [2:0][mrpc_pkg::mrpc_rw(FRAC_BITS)-1:0]    stage_rem,
  output logic [2:0][mrpc_pkg::QBITS-1:0]                 stage_xl,
  output logic [mrpc_pkg::mrpc_dsw(FRAC_BITS)-1:0]        stage_divisor,
  output mrpc_pkg::flags_t                                stage_flags
);
  import mrpc_pkg::*;

  localparam int DSW = mrpc_dsw(FRAC_BITS);
  localparam int NW  = mrpc_nw(FRAC_BITS);
  localparam int RW  = mrpc_rw(FRAC_BITS);
  localparam int CW  = mrpc_cw(FRAC_BITS);
  localparam logic signed [DSW-1:0] S4C = DSW'(1) <<< (4 * FRAC_BITS);

  // stage 1: input register
  logic  vld1;
  req_t  req1;
  logic signed [31:0] av [3];
  logic signed [31:0] bv [3];

  // stage 2: 32x32 products
  logic vld2;
  logic signed [63:0] sq_a [3];
  logic signed [63:0] sq_b [3];
  logic signed [63:0] pab  [3];
  logic signed [63:0] crt  [3];
  logic signed [63:0] cru  [3];
  logic signed [31:0] a2 [3];
  logic signed [31:0] b2 [3];

  // stage 3: norms, dot and cross products
  logic vld3;
  logic [63:0] asq;
  logic [63:0] bsq;
  logic signed [65:0] pdot3;
  logic signed [64:0] cr3 [3];
  logic signed [31:0] a3 [3];
  logic signed [31:0] b3 [3];

  // stage 4: partial products of the wide terms
  logic vld4;
  logic [63:0] pp_ll;
  logic [63:0] pp_lh;
  logic [63:0] pp_hl;
  logic [63:0] pp_hh;
  logic signed [64:0] mbh [3];
  logic signed [64:0] mbl [3];
  logic signed [64:0] mah [3];
  logic signed [64:0] mal [3];
  logic signed [65:0] pdot4;
  logic signed [64:0] cr4 [3];
  logic signed [31:0] a4 [3];
  logic signed [31:0] b4 [3];

  // stage 5: assembled products
  logic vld5;
  logic [127:0] abp;
  logic signed [96:0] ba [3];
  logic signed [96:0] ab [3];
  logic signed [65:0] pdot5;
  logic signed [64:0] cr5 [3];
  logic signed [31:0] a5 [3];
  logic signed [31:0] b5 [3];

  // stage 6: denominator and numerators
  logic vld6;
  logic signed [DSW-1:0] dd;
  logic signed [NW-1:0]  n0 [3];

  // stage 7 inputs
  logic [NW-1:0] mag [3];
  logic [CW-1:0] xf  [3];
  logic [CW-1:0] yc;
  logic [CW-1:0] dext;

  always_comb begin
    av[0] = req1.a_x;
    av[1] = req1.a_y;
    av[2] = req1.a_z;
    bv[0] = req1.b_x;
    bv[1] = req1.b_y;
    bv[2] = req1.b_z;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1      <= 1'b0;
      vld2      <= 1'b0;
      vld3      <= 1'b0;
      vld4      <= 1'b0;
      vld5      <= 1'b0;
      vld6      <= 1'b0;
      stage_vld <= 1'b0;
    end else if (en) begin
      vld1      <= vld;
      vld2      <= vld1;
      vld3      <= vld2;
      vld4      <= vld3;
      vld5      <= vld4;
      vld6      <= vld5;
      stage_vld <= vld6;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      req1 <= data;
      for (int i = 0; i < 3; i++) begin
        sq_a[i] <= av[i] * av[i];
        sq_b[i] <= bv[i] * bv[i];
        pab[i]  <= av[i] * bv[i];
        crt[i]  <= bv[(i + 1) % 3] * av[(i + 2) % 3];
        cru[i]  <= bv[(i + 2) % 3] * av[(i + 1) % 3];
        a2[i]   <= av[i];
        b2[i]   <= bv[i];
      end

      asq   <= 64'(sq_a[0] + sq_a[1] + sq_a[2]);
      bsq   <= 64'(sq_b[0] + sq_b[1] + sq_b[2]);
      pdot3 <= 66'(pab[0]) + 66'(pab[1]) + 66'(pab[2]);
      for (int i = 0; i < 3; i++) begin
        cr3[i] <= 65'(crt[i]) - 65'(cru[i]);
        a3[i]  <= a2[i];
        b3[i]  <= b2[i];
      end

      pp_ll <= asq[31:0] * bsq[31:0];
      pp_lh <= asq[31:0] * bsq[63:32];
      pp_hl <= asq[63:32] * bsq[31:0];
      pp_hh <= asq[63:32] * bsq[63:32];
      pdot4 <= pdot3;
      for (int i = 0; i < 3; i++) begin
        mbh[i] <= $signed({1'b0, bsq[63:32]}) * a3[i];
        mbl[i] <= $signed({1'b0, bsq[31:0]}) * a3[i];
        mah[i] <= $signed({1'b0, asq[63:32]}) * b3[i];
        mal[i] <= $signed({1'b0, asq[31:0]}) * b3[i];
        cr4[i] <= cr3[i];
        a4[i]  <= a3[i];
        b4[i]  <= b3[i];
      end

      abp <= {pp_hh, 64'd0} + {32'd0, pp_hl, 32'd0} + {32'd0, pp_lh, 32'd0}
           + {64'd0, pp_ll};
      pdot5 <= pdot4;
      for (int i = 0; i < 3; i++) begin
        ba[i]  <= (97'(mbh[i]) <<< 32) + 97'(mbl[i]);
        ab[i]  <= (97'(mah[i]) <<< 32) + 97'(mal[i]);
        cr5[i] <= cr4[i];
        a5[i]  <= a4[i];
        b5[i]  <= b4[i];
      end

      dd <= S4C + DSW'(abp) - (DSW'(pdot5) <<< (2 * FRAC_BITS + 1));
      for (int i = 0; i < 3; i++) begin
        n0[i] <= (NW'(a5[i]) <<< (2 * FRAC_BITS)) + (NW'(b5[i]) <<< (2 * FRAC_BITS))
               - NW'(ba[i]) - NW'(ab[i]) - (NW'(cr5[i]) <<< (FRAC_BITS + 1));
      end
    end
  end

  // rounding dividend 2|n| + d against divisor 2d
  always_comb begin
    dext = CW'(unsigned'(dd));
    yc   = dext << (QBITS + 1);
    for (int i = 0; i < 3; i++) begin
      mag[i] = n0[i][NW-1] ? NW'(-n0[i]) : NW'(n0[i]);
      xf[i]  = (CW'(mag[i]) << (2 * FRAC_BITS + 1)) + dext;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stage_divisor    <= DSW'(unsigned'(dd)) << 1;
      stage_flags.zero <= dd[DSW-1] | (dd == '0);
      for (int i = 0; i < 3; i++) begin
        stage_rem[i]       <= RW'(xf[i] >> QBITS);
        stage_xl[i]        <= xf[i][QBITS-1:0];
        stage_flags.neg[i] <= n0[i][NW-1];
        stage_flags.ovf[i] <= xf[i] >= yc;
      end
    end
  end

endmodule

### design/mrpc_div.sv
`timescale 1ns / 1ps
module mrpc_div #(
  parameter int FRAC_BITS = 28,
  parameter int STEP      = 0
) (
  input  logic                                            clk,
  input  logic                                            rst,
  input  logic                                            en,
  input  logic                                            vld,
  input  logic [2:0][mrpc_pkg::mrpc_rw(FRAC_BITS)-1:0]    rem,
  input  logic [2:0][mrpc_pkg::QBITS-1:0]                 xl,
  input  logic [2:0][mrpc_pkg::QBITS-1:0]                 quo,
  input  logic [mrpc_pkg::mrpc_dsw(FRAC_BITS)-1:0]        divisor,
  input  mrpc_pkg::flags_t                                flags,
  output logic                                            stage_vld,
  output logic [2:0][mrpc_pkg::mrpc_rw(FRAC_BITS)-1:0]    stage_rem,
  output logic [2:0][mrpc_pkg::QBITS-1:0]                 stage_xl,
  output logic [2:0][mrpc_pkg::QBITS-1:0]                 stage_quo,
  output logic [mrpc_pkg::mrpc_dsw(FRAC_BITS)-1:0]        stage_divisor,
  output mrpc_pkg::flags_t                                stage_flags
);
  import mrpc_pkg::*;

  localparam int RW = mrpc_rw(FRAC_BITS);

  logic [RW-1:0] trial    [3];
  logic [RW-1:0] rem_next [3];
  logic [2:0]    ge;

  // one restoring step per lane
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      trial[i]    = {rem[i][RW-2:0], xl[i][QBITS-1-STEP]};
      ge[i]       = trial[i] >= {1'b0, divisor};
      rem_next[i] = ge[i] ? trial[i] - {1'b0, divisor} : trial[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_vld <= 1'b0;
    end else if (en) begin
      stage_vld <= vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stage_divisor <= divisor;
      stage_flags   <= flags;
      for (int i = 0; i < 3; i++) begin
        stage_rem[i] <= rem_next[i];
        stage_xl[i]  <= xl[i];
        stage_quo[i] <= {quo[i][QBITS-2:0], ge[i]};
      end
    end
  end

endmodule

### design/mrpc_round.sv
`timescale 1ns / 1ps
module mrpc_round (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  logic                            vld,
  input  logic [2:0][mrpc_pkg::QBITS-1:0] quo,
  input  mrpc_pkg::flags_t                flags,
  output logic                            rsp_valid,
  output mrpc_pkg::rsp_t                  rsp_data
);
  import mrpc_pkg::*;

  logic [31:0] lim [3];
  logic [31:0] val [3];
  logic [2:0]  sat;
  rsp_t        rsp_next;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lim[i] = flags.neg[i] ? SAT_NEG : SAT_POS;
      sat[i] = flags.ovf[i] | (quo[i] > lim[i]);
      if (sat[i]) begin
        val[i] = lim[i];
      end else begin
        val[i] = flags.neg[i] ? (32'd0 - quo[i]) : quo[i];
      end
    end
    if (flags.zero) begin
      rsp_next.out_x  = '0;
      rsp_next.out_y  = '0;
      rsp_next.out_z  = '0;
      rsp_next.status = ST_ZERO;
    end else begin
      rsp_next.out_x  = val[0];
      rsp_next.out_y  = val[1];
      rsp_next.out_z  = val[2];
      rsp_next.status = (|sat) ? ST_SAT : ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (en) begin
      rsp_valid <= vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rsp_data <= rsp_next;
    end
  end

endmodule

### design/mrp_compose_top.sv
`timescale 1ns / 1ps
// Composes two rotations given as modified Rodrigues parameter vectors, one pair per
// clock while no stall holds the pipe: the front end forms the norms, products,
// denominator and scaled numerators, a pipelined restoring divider follows (one
// quotient bit per stage, three lanes side by side), and the last stage rounds,
// saturates and registers the result. The whole pipe
// advances together and holds while a finished item waits on rsp_ready.
module mrp_compose_top #(
  parameter int FRAC_BITS = 28
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  mrpc_pkg::req_t req_data,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output mrpc_pkg::rsp_t rsp_data
);
  import mrpc_pkg::*;

  localparam int RW  = mrpc_rw(FRAC_BITS);
  localparam int DSW = mrpc_dsw(FRAC_BITS);

  logic en;

  logic [QBITS:0]                  c_vld;
  logic [QBITS:0][2:0][RW-1:0]     c_rem;
  logic [QBITS:0][2:0][QBITS-1:0]  c_xl;
  logic [QBITS:0][2:0][QBITS-1:0]  c_quo;
  logic [QBITS:0][DSW-1:0]         c_div;
  flags_t [QBITS:0]                c_flags;

  assign en        = ~rsp_valid | rsp_ready;
  assign req_ready = en;
  assign c_quo[0]  = '0;

  mrpc_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .en            (en),
    .vld           (req_valid),
    .data          (req_data),
    .stage_vld     (c_vld[0]),
    .stage_rem     (c_rem[0]),
    .stage_xl      (c_xl[0]),
    .stage_divisor (c_div[0]),
    .stage_flags   (c_flags[0])
  );

  for (genvar k = 0; k < QBITS; k++) begin : g_div
    mrpc_div #(
      .FRAC_BITS (FRAC_BITS),
      .STEP      (k)
    ) u_div (
      .clk           (clk),
      .rst           (rst),
      .en            (en),
      .vld           (c_vld[k]),
      .rem           (c_rem[k]),
      .xl            (c_xl[k]),
      .quo           (c_quo[k]),
      .divisor       (c_div[k]),
      .flags         (c_flags[k]),
      .stage_vld     (c_vld[k+1]),
      .stage_rem     (c_rem[k+1]),
      .stage_xl      (c_xl[k+1]),
      .stage_quo     (c_quo[k+1]),
      .stage_divisor (c_div[k+1]),
      .stage_flags   (c_flags[k+1])
    );
  end

  mrpc_round u_round (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .vld       (c_vld[QBITS]),
    .quo       (c_quo[QBITS]),
    .flags     (c_flags[QBITS]),
    .rsp_valid (rsp_valid),
    .rsp_data  (rsp_data)
  );

  a_sat_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.status == ST_SAT |->
      unsigned'(rsp_data.out_x) == SAT_POS || unsigned'(rsp_data.out_x) == SAT_NEG ||
      unsigned'(rsp_data.out_y) == SAT_POS || unsigned'(rsp_data.out_y) == SAT_NEG ||
      unsigned'(rsp_data.out_z) == SAT_POS || unsigned'(rsp_data.out_z) == SAT_NEG)
    else $error("saturated item with no component at a bound");

  a_zero_out: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.status == ST_ZERO |->
      rsp_data.out_x == '0 && rsp_data.out_y == '0 && rsp_data.out_z == '0)
    else $error("zero denominator item with nonzero components");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(c_vld))
    else $error("divider pipe moved during a stall");

endmodule

### sim/tb.sv
`timescale 1ns / 1ps
module tb;
  import mrpc_pkg::*;

  localparam int FB = 28;
  localparam int UNIT = 1 << FB;

  typedef logic signed [319:0] wide_t;

  logic clk = 0;
  logic rst = 1;
  logic req_valid = 0;
  logic req_ready;
  req_t req_data = '0;
  logic rsp_valid;
  logic rsp_ready = 0;
  rsp_t rsp_data;

  rsp_t expected_q[$];
  int errors = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_zero = 0;
  int n_sat = 0;
  bit tx_eager = 0;
  bit rx_eager = 0;
  int hold_req = 0;

  mrp_compose_top #(.FRAC_BITS(FB)) uut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req_data(req_data),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp_data(rsp_data)
  );

  always #5 clk = ~clk;

  function automatic wide_t widen(logic [31:0] v);
    return {{288{v[31]}}, v};
  endfunction

  // exact composition, rounded half away from zero, saturated
  function automatic rsp_t compose_mrp(req_t r);
    wide_t av[3];
    wide_t bv[3];
    wide_t cr[3];
    wide_t aa, bb, ab, s2, s4, d, n, num, den, q, lim;
    logic neg;
    rsp_t o;
    av[0] = widen(r.a_x); av[1] = widen(r.a_y); av[2] = widen(r.a_z);
    bv[0] = widen(r.b_x); bv[1] = widen(r.b_y); bv[2] = widen(r.b_z);
    aa = av[0] * av[0] + av[1] * av[1] + av[2] * av[2];
    bb = bv[0] * bv[0] + bv[1] * bv[1] + bv[2] * bv[2];
    ab = av[0] * bv[0] + av[1] * bv[1] + av[2] * bv[2];
    s2 = wide_t'(1) <<< (2 * FB);
    s4 = wide_t'(1) <<< (4 * FB);
    d = s4 + aa * bb - ((s2 * ab) <<< 1);
    o = '0;
    if (d <= 0) begin
      o.status = ST_ZERO;
      return o;
    end
    o.status = ST_OK;
    cr[0] = bv[1] * av[2] - bv[2] * av[1];
    cr[1] = bv[2] * av[0] - bv[0] * av[2];
    cr[2] = bv[0] * av[1] - bv[1] * av[0];
    for (int i = 0; i < 3; i++) begin
      logic [31:0] val;
      n = (s2 - bb) * av[i] + (s2 - aa) * bv[i] - (cr[i] <<< (FB + 1));
      n = n <<< (2 * FB);
      neg = n < 0;
      if (neg) n = -n;
      num = (n <<< 1) + d;
      den = d <<< 1;
      q = num / den;
      lim = neg ? (wide_t'(1) <<< 31) : ((wide_t'(1) <<< 31) - 1);
      if (q > lim) begin
        val = neg ? SAT_NEG : SAT_POS;
        o.status = ST_SAT;
      end else begin
        val = neg ? -q[31:0] : q[31:0];
      end
      case (i)
        0: o.out_x = val;
        1: o.out_y = val;
        default: o.out_z = val;
      endcase
    end
    return o;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // accepted items get their prediction here
  always @(posedge clk) begin
    if (!rst && req_valid && req_ready) begin
      expected_q.push_back(compose_mrp(req_data));
      n_sent++;
    end
  end

  always @(posedge clk) begin
    rsp_t e;
    if (!rst && rsp_valid && rsp_ready) begin
      if (expected_q.size() == 0) begin
        $error("result with nothing expected: %h", rsp_data);
        errors++;
      end else begin
        e = expected_q.pop_front();
        n_checked++;
        if (e.status == ST_ZERO) n_zero++;
        if (e.status == ST_SAT) n_sat++;
        if (rsp_data.out_x !== e.out_x) begin
          $error("out_x expected %h actual %h", e.out_x, rsp_data.out_x);
          errors++;
        end
        if (rsp_data.out_y !== e.out_y) begin
          $error("out_y expected %h actual %h", e.out_y, rsp_data.out_y);
          errors++;
        end
        if (rsp_data.out_z !== e.out_z) begin
          $error("out_z expected %h actual %h", e.out_z, rsp_data.out_z);
          errors++;
        end
        if (rsp_data.status !== e.status) begin
          $error("status expected %0d actual %0d", e.status, rsp_data.status);
          errors++;
        end
      end
    end
  end

  // receiver stalls, with a long hold on request
  initial begin
    int hold_cnt;
    int gap;
    hold_cnt = 0;
    gap = 0;
    forever begin
      @(posedge clk);
      if (hold_req > 0) begin
        hold_cnt = hold_req;
        hold_req = 0;
      end
      if (rst) begin
        rsp_ready <= 0;
      end else if (hold_cnt > 0) begin
        rsp_ready <= 0;
        hold_cnt--;
      end else if (gap > 0) begin
        rsp_ready <= 0;
        gap--;
      end else begin
        rsp_ready <= 1;
        gap = rx_eager ? 0 : pick_gap();
      end
    end
  end

  task automatic send_item(req_t r);
    int gap;
    req_valid <= 1;
    req_data <= r;
    do @(posedge clk); while (!req_ready);
    gap = tx_eager ? 0 : pick_gap();
    if (gap > 0) begin
      req_valid <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic idle_tx();
    req_valid <= 0;
    @(posedge clk);
  endtask

  task automatic drain();
    idle_tx();
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  function automatic req_t mk(int ax, int ay, int az, int bx, int by, int bz);
    req_t r;
    r.a_x = ax; r.a_y = ay; r.a_z = az;
    r.b_x = bx; r.b_y = by; r.b_z = bz;
    return r;
  endfunction

  function automatic logic [31:0] rand_comp(int kind);
    case (kind)
      0: return $urandom;
      1: return $urandom_range(0, 2 * UNIT) - UNIT;
      2: return $urandom_range(0, 1 << 20) - (1 << 19);
      default: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
    endcase
  endfunction

  // unit axis vector for zero denominator
  function automatic req_t unit_pair();
    req_t r;
    int ax;
    logic [31:0] v;
    r = '0;
    ax = $urandom_range(0, 2);
    v = $urandom_range(0, 1) ? UNIT : -UNIT;
    case (ax)
      0: begin r.a_x = v; r.b_x = v; end
      1: begin r.a_y = v; r.b_y = v; end
      default: begin r.a_z = v; r.b_z = v; end
    endcase
    return r;
  endfunction

  task automatic test_directed();
    int mx, mn;
    mx = 32'h7fff_ffff;
    mn = 32'h8000_0000;
    send_item(mk(0, 0, 0, 0, 0, 0));
    send_item(mk(mx, mx, mx, mx, mx, mx));
    send_item(mk(mn, mn, mn, mn, mn, mn));
    send_item(mk(mx, mn, mx, mn, mx, mn));
    send_item(mk(UNIT, 0, 0, UNIT, 0, 0));
    send_item(mk(0, -UNIT, 0, 0, -UNIT, 0));
    send_item(mk(0, 0, UNIT, 0, 0, -UNIT));
    send_item(mk(UNIT / 2, 0, 0, 0, UNIT / 2, 0));
    send_item(mk(UNIT, 0, 0, 0, 0, 0));
    send_item(mk(0, 0, 0, 0, UNIT, 0));
    send_item(mk(UNIT - 1, 0, 0, UNIT - 1, 0, 0));
    send_item(mk(UNIT + 1, 0, 0, UNIT, 0, 0));
    send_item(mk(mx, 0, 0, 0, 0, 0));
    send_item(mk(0, 0, 0, mn, 0, 0));
    send_item(mk(1, -1, 1, -1, 1, -1));
    send_item(mk(mx, 0, 0, mn, 0, 0));
    send_item(mk(UNIT / 4, UNIT / 3, -UNIT / 5, -UNIT / 7, UNIT / 2, UNIT / 9));
    send_item(mk(-1, -1, -1, -1, -1, -1));
    drain();
  endtask

  task automatic test_random(int count);
    req_t r;
    int sel;
    int k;
    for (int i = 0; i < count; i++) begin
      if (i % 200 == 0) tx_eager = ($urandom_range(0, 3) == 0);
      if (i % 170 == 0) rx_eager = ($urandom_range(0, 3) == 0);
      sel = $urandom_range(0, 99);
      if (sel < 8) begin
        r = unit_pair();
      end else begin
        k = (sel < 40) ? 0 : (sel < 80) ? 1 : (sel < 92) ? 2 : 4;
        r.a_x = (k == 4) ? rand_comp($urandom_range(0, 3)) : rand_comp(k);
        r.a_y = (k == 4) ? rand_comp($urandom_range(0, 3)) : rand_comp(k);
        r.a_z = (k == 4) ? rand_comp($urandom_range(0, 3)) : rand_comp(k);
        r.b_x = (k == 4) ? rand_comp($urandom_range(0, 3)) : rand_comp(k);
        r.b_y = (k == 4) ? rand_comp($urandom_range(0, 3)) : rand_comp(k);
        r.b_z = (k == 4) ? rand_comp($urandom_range(0, 3)) : rand_comp(k);
      end
      send_item(r);
    end
    tx_eager = 0;
    rx_eager = 0;
    drain();
  endtask

  task automatic test_backpressure();
    hold_req = 300;
    tx_eager = 1;
    for (int i = 0; i < 90; i++)
      send_item(mk(rand_comp(1), rand_comp(1), rand_comp(1),
                   rand_comp(1), rand_comp(1), rand_comp(1)));
    tx_eager = 0;
    drain();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random(1640);
    repeat (60) @(posedge clk);
    $display("covered %0d items: %0d saturated, %0d zero denominator", n_checked, n_sat,
             n_zero);
    $display("directed extremes, long receiver hold and random mixed-range vectors");
    if (errors == 0 && expected_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

### mrp_compose_top.f
design/mrpc_pkg.sv
design/mrpc_front.sv
design/mrpc_div.sv
design/mrpc_round.sv
design/mrp_compose_top.sv
sim/tb.sv
